>>> rtl/pmfp_pkg.sv
`default_nettype none
package pmfp_pkg;

  localparam int DEV_W = 5;

  // Byte positions within a frame. Byte 1 and the checksum byte 23 are skipped.
  localparam logic [4:0] POS_STATE    = 5'd0;
  localparam logic [4:0] POS_VPARAM   = 5'd2;
  localparam logic [4:0] POS_VDATA    = 5'd5;
  localparam logic [4:0] POS_CPARAM   = 5'd8;
  localparam logic [4:0] POS_CDATA    = 5'd11;
  localparam logic [4:0] POS_PPARAM   = 5'd14;
  localparam logic [4:0] POS_PDATA    = 5'd17;
  localparam logic [4:0] POS_FLAGS    = 5'd20;
  localparam logic [4:0] POS_PULSE_LO = 5'd21;
  localparam logic [4:0] POS_CHECKSUM = 5'd23;
  localparam logic [4:0] POS_PULSE_HI = 5'd24;
  localparam logic [4:0] POS_LAST     = 5'd28;
  localparam logic [4:0] FRAME_LEN    = 5'd29;

  localparam logic [7:0] TRAILER  = 8'h55;
  localparam logic [7:0] OVF_MASK = 8'hF0;

  // Update flag bits in byte 20.
  localparam int FLAG_V = 6;
  localparam int FLAG_C = 5;
  localparam int FLAG_P = 4;

  // State register bits used in an overflow report.
  localparam int ST_OVF_N = 0;
  localparam int ST_P     = 1;
  localparam int ST_C     = 2;
  localparam int ST_V     = 3;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             frame_start;
    logic [DEV_W-1:0] device_index;
    logic             relay_on;
  } pmfp_in_t;

  typedef struct packed {
    logic [DEV_W-1:0] out_device;
    logic [7:0]       state_reg;
    logic [23:0]      voltage_param;
    logic [23:0]      voltage_data;
    logic [23:0]      current_param;
    logic [23:0]      current_data;
    logic [23:0]      power_param;
    logic [23:0]      power_data;
    logic [47:0]      total_pulses;
  } pmfp_out_t;

  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic             relay;
    logic [7:0]       state;
    logic [7:0]       flags;
    logic [23:0]      vparam;
    logic [23:0]      vdata;
    logic [23:0]      cparam;
    logic [23:0]      cdata;
    logic [23:0]      pparam;
    logic [23:0]      pdata;
    logic [15:0]      pulse_low;
    logic [31:0]      pulse_high;
  } pmfp_frame_t;

  typedef struct packed {
    logic [23:0] voltage;
    logic [23:0] current;
    logic [23:0] power;
  } pmfp_kept_t;

  typedef struct packed {
    logic       en;
    pmfp_kept_t data;
  } pmfp_wr_t;

endpackage
`default_nettype wire

>>> rtl/pmfp_collect.sv
`default_nettype none
module pmfp_collect (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire pmfp_pkg::pmfp_in_t   in_data,
  output pmfp_pkg::pmfp_frame_t     frame,
  output logic                      last_pos,
  output logic                      fire
);

  logic [4:0]  count_r;
  logic [4:0]  idx;
  logic        active;
  logic        take;
  logic [pmfp_pkg::DEV_W-1:0] device_r;
  logic        relay_r;
  logic [7:0]  state_r;
  logic [7:0]  flags_r;
  logic [23:0] vparam_r;
  logic [23:0] vdata_r;
  logic [23:0] cparam_r;
  logic [23:0] cdata_r;
  logic [23:0] pparam_r;
  logic [23:0] pdata_r;
  logic [15:0] pulse_low_r;
  logic [31:0] pulse_high_r;
  logic [7:0]  b;

  always_comb begin
    b        = in_data.data_byte;
    idx      = in_data.frame_start ? pmfp_pkg::POS_STATE : count_r;
    active   = in_data.frame_start || (count_r < pmfp_pkg::FRAME_LEN);
    take     = accept && active;
    last_pos = !in_data.frame_start && (count_r == pmfp_pkg::POS_LAST);
    fire     = take && (idx == pmfp_pkg::POS_LAST) && (b == pmfp_pkg::TRAILER);
  end

  // A frame start always restarts at byte 0, dropping any partial frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= pmfp_pkg::FRAME_LEN;
      device_r <= '0;
      relay_r  <= 1'b0;
    end else begin
      if (accept && in_data.frame_start) begin
        device_r <= in_data.device_index;
        relay_r  <= in_data.relay_on;
      end
      if (take) begin
        count_r <= (idx == pmfp_pkg::POS_LAST) ? pmfp_pkg::FRAME_LEN : idx + 5'd1;
      end
    end
  end

  // Multi-byte fields arrive most significant byte first.
  always_ff @(posedge clk) begin
    if (take) begin
      case (idx) inside
        pmfp_pkg::POS_STATE: state_r <= b;
        [pmfp_pkg::POS_VPARAM:pmfp_pkg::POS_VDATA - 5'd1]:
          vparam_r <= {vparam_r[15:0], b};
        [pmfp_pkg::POS_VDATA:pmfp_pkg::POS_CPARAM - 5'd1]:
          vdata_r <= {vdata_r[15:0], b};
        [pmfp_pkg::POS_CPARAM:pmfp_pkg::POS_CDATA - 5'd1]:
          cparam_r <= {cparam_r[15:0], b};
        [pmfp_pkg::POS_CDATA:pmfp_pkg::POS_PPARAM - 5'd1]:
          cdata_r <= {cdata_r[15:0], b};
        [pmfp_pkg::POS_PPARAM:pmfp_pkg::POS_PDATA - 5'd1]:
          pparam_r <= {pparam_r[15:0], b};
        [pmfp_pkg::POS_PDATA:pmfp_pkg::POS_FLAGS - 5'd1]:
          pdata_r <= {pdata_r[15:0], b};
        pmfp_pkg::POS_FLAGS: flags_r <= b;
        [pmfp_pkg::POS_PULSE_LO:pmfp_pkg::POS_CHECKSUM - 5'd1]:
          pulse_low_r <= {pulse_low_r[7:0], b};
        [pmfp_pkg::POS_PULSE_HI:pmfp_pkg::POS_LAST - 5'd1]:
          pulse_high_r <= {pulse_high_r[23:0], b};
        default: ;
      endcase
    end
  end

  always_comb begin
    frame.device     = device_r;
    frame.relay      = relay_r;
    frame.state      = state_r;
    frame.flags      = flags_r;
    frame.vparam     = vparam_r;
    frame.vdata      = vdata_r;
    frame.cparam     = cparam_r;
    frame.cdata      = cdata_r;
    frame.pparam     = pparam_r;
    frame.pdata      = pdata_r;
    frame.pulse_low  = pulse_low_r;
    frame.pulse_high = pulse_high_r;
  end

endmodule
`default_nettype wire

>>> rtl/pmfp_kept_store.sv
`default_nettype none
module pmfp_kept_store #(
  parameter int DEVICE_COUNT = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [pmfp_pkg::DEV_W-1:0]   dev,
  input  wire pmfp_pkg::pmfp_wr_t           wr,
  output pmfp_pkg::pmfp_kept_t              kept
);

  localparam int AW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int IW = (AW > pmfp_pkg::DEV_W) ? AW : pmfp_pkg::DEV_W;

  pmfp_pkg::pmfp_kept_t mem [DEVICE_COUNT];
  logic [DEVICE_COUNT-1:0] valid_r;
  logic [IW-1:0]           dev_ext;
  logic [AW-1:0]           addr;
  logic                    in_range;
  logic                    hit_r;
  pmfp_pkg::pmfp_kept_t    rd_data_r;

  always_comb begin
    dev_ext  = IW'(dev);
    addr     = dev_ext[AW-1:0];
    in_range = 32'(dev) < DEVICE_COUNT;
  end

  // Entries never written read as zero; devices beyond the store are not kept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      hit_r <= in_range && valid_r[addr];
      if (wr.en && in_range) begin
        valid_r[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && in_range) begin
      mem[addr] <= wr.data;
    end
    rd_data_r <= mem[addr];
  end

  assign kept = hit_r ? rd_data_r : '0;

endmodule
`default_nettype wire

>>> rtl/pmfp_finish.sv
`default_nettype none
module pmfp_finish (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire pmfp_pkg::pmfp_frame_t  frame,
  input  wire pmfp_pkg::pmfp_kept_t   kept,
  input  wire logic                   fire,
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output pmfp_pkg::pmfp_out_t         out_data,
  output pmfp_pkg::pmfp_wr_t          wr
);

  logic                 out_valid_r;
  pmfp_pkg::pmfp_out_t  out_data_r;
  pmfp_pkg::pmfp_out_t  out_data_nxt;
  logic [23:0]          v;
  logic [23:0]          c;
  logic [23:0]          p;
  logic                 ovf;

  always_comb begin
    v = frame.flags[pmfp_pkg::FLAG_V] ? frame.vdata : kept.voltage;
    c = frame.flags[pmfp_pkg::FLAG_C] ? frame.cdata : kept.current;
    p = frame.flags[pmfp_pkg::FLAG_P] ? frame.pdata : kept.power;
    ovf = ((frame.state & pmfp_pkg::OVF_MASK) == pmfp_pkg::OVF_MASK) &&
          !frame.state[pmfp_pkg::ST_OVF_N];
    // An overflow report zeroes single values, and the current also when the
    // relay is off; any other state but the normal one zeroes them all.
    if (ovf) begin
      if (frame.state[pmfp_pkg::ST_P]) p = '0;
      if (frame.state[pmfp_pkg::ST_C] || !frame.relay) c = '0;
      if (frame.state[pmfp_pkg::ST_V]) v = '0;
    end else if (frame.state != pmfp_pkg::TRAILER) begin
      v = '0;
      c = '0;
      p = '0;
    end

    out_data_nxt.out_device    = frame.device;
    out_data_nxt.state_reg     = frame.state;
    out_data_nxt.voltage_param = frame.vparam;
    out_data_nxt.voltage_data  = v;
    out_data_nxt.current_param = frame.cparam;
    out_data_nxt.current_data  = c;
    out_data_nxt.power_param   = frame.pparam;
    out_data_nxt.power_data    = p;
    out_data_nxt.total_pulses  = {frame.pulse_high, frame.pulse_low};

    wr.en           = fire;
    wr.data.voltage = v;
    wr.data.current = c;
    wr.data.power   = p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> rtl/power_meter_frame_parser.sv
// Energy-meter frame parser.
// The input channel carries one frame byte per beat, most significant byte
// first, with frame_start marking byte 0 and the device index and relay state
// sampled on that beat. A frame is 29 bytes; bytes outside a frame are dropped.
// After the last byte, if it is the 0x55 trailer, one reading is presented on
// the output channel in the cycle after that beat is accepted. Data values not
// flagged as updated come from the per-device kept values, which are then
// overwritten with the final (possibly zeroed) values.
// Throughput is one byte per cycle while in_stall is low; the staging registers
// and the kept-value memory are each touched once per beat. The kept values are
// read ahead during the frame, so they are ready when the last byte arrives.
// in_stall rises only when the next byte due is the last of a frame and the
// previous reading is still held by a stalled receiver; the output register
// keeps that reading unchanged until it is taken.
// Reset idles the byte counter, drops any pending reading and makes every
// device's kept values read as zero.
`default_nettype none
module power_meter_frame_parser #(
  parameter int DEVICE_COUNT = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pmfp_pkg::pmfp_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pmfp_pkg::pmfp_out_t       out_data
);

  pmfp_pkg::pmfp_frame_t frame;
  pmfp_pkg::pmfp_kept_t  kept;
  pmfp_pkg::pmfp_wr_t    wr;
  logic                  last_pos;
  logic                  fire;
  logic                  accept;

  assign in_stall = out_valid && out_stall && last_pos;
  assign accept   = in_valid && !in_stall;

  pmfp_collect u_collect (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .frame    (frame),
    .last_pos (last_pos),
    .fire     (fire)
  );

  pmfp_kept_store #(
    .DEVICE_COUNT (DEVICE_COUNT)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .dev   (frame.device),
    .wr    (wr),
    .kept  (kept)
  );

  pmfp_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame     (frame),
    .kept      (kept),
    .fire      (fire),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .wr        (wr)
  );

endmodule
`default_nettype wire

>>> rtl/pmfp_checker.sv
`default_nettype none
module pmfp_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire pmfp_pkg::pmfp_in_t   in_data,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire pmfp_pkg::pmfp_out_t  out_data
);

  // A held reading stays put while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("reading changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("reading pending after reset");

  // A new reading follows only an accepted trailer byte.
  a_rise_on_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && !in_data.frame_start &&
                               in_data.data_byte == pmfp_pkg::TRAILER))
    else $error("reading without a trailer byte");

  // Any state other than normal or an overflow report zeroes all data.
  a_bad_state_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.state_reg != pmfp_pkg::TRAILER &&
    !(out_data.state_reg[7:4] == 4'hF && !out_data.state_reg[0])
    |-> out_data.voltage_data == 24'd0 && out_data.current_data == 24'd0 &&
        out_data.power_data == 24'd0)
    else $error("bad state did not zero the data");

endmodule

bind power_meter_frame_parser pmfp_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

>>> dv/pmfp_reading_checker.sv
`timescale 1ns / 1ps
module pmfp_reading_checker #(
  parameter int DEVICE_COUNT = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pmfp_pkg::pmfp_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pmfp_pkg::pmfp_out_t out_data,
  output int                  fail_count,
  output int                  readings_due
);
  import pmfp_pkg::*;

  int          frame_pos;
  pmfp_frame_t staged;
  pmfp_kept_t  kept [DEVICE_COUNT];
  pmfp_out_t   readings_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [47:0] got,
                               input logic [47:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Resolves the data values of a completed frame and updates the kept values.
  task automatic close_frame();
    pmfp_kept_t vals;
    pmfp_out_t  r;
    logic       in_range;
    in_range = staged.device < DEVICE_COUNT;
    vals = in_range ? kept[staged.device] : '0;
    if (staged.flags[FLAG_V]) vals.voltage = staged.vdata;
    if (staged.flags[FLAG_C]) vals.current = staged.cdata;
    if (staged.flags[FLAG_P]) vals.power = staged.pdata;
    if ((staged.state & OVF_MASK) == OVF_MASK && !staged.state[ST_OVF_N]) begin
      if (staged.state[ST_P]) vals.power = '0;
      if (staged.state[ST_C] || !staged.relay) vals.current = '0;
      if (staged.state[ST_V]) vals.voltage = '0;
    end else if (staged.state != TRAILER) begin
      vals = '0;
    end
    if (in_range) kept[staged.device] = vals;
    r.out_device    = staged.device;
    r.state_reg     = staged.state;
    r.voltage_param = staged.vparam;
    r.voltage_data  = vals.voltage;
    r.current_param = staged.cparam;
    r.current_data  = vals.current;
    r.power_param   = staged.pparam;
    r.power_data    = vals.power;
    r.total_pulses  = {staged.pulse_high, staged.pulse_low};
    readings_q.push_back(r);
  endtask

  task automatic take_beat(input pmfp_in_t beat);
    int         pos;
    logic [7:0] b;
    b = beat.data_byte;
    if (beat.frame_start) begin
      frame_pos     = 0;
      staged.device = beat.device_index;
      staged.relay  = beat.relay_on;
    end
    if (frame_pos >= FRAME_LEN) return;
    pos = frame_pos;
    frame_pos++;
    if (pos == POS_STATE) staged.state = b;
    else if (pos >= POS_VPARAM && pos < POS_VDATA) staged.vparam = {staged.vparam[15:0], b};
    else if (pos >= POS_VDATA && pos < POS_CPARAM) staged.vdata = {staged.vdata[15:0], b};
    else if (pos >= POS_CPARAM && pos < POS_CDATA) staged.cparam = {staged.cparam[15:0], b};
    else if (pos >= POS_CDATA && pos < POS_PPARAM) staged.cdata = {staged.cdata[15:0], b};
    else if (pos >= POS_PPARAM && pos < POS_PDATA) staged.pparam = {staged.pparam[15:0], b};
    else if (pos >= POS_PDATA && pos < POS_FLAGS) staged.pdata = {staged.pdata[15:0], b};
    else if (pos == POS_FLAGS) staged.flags = b;
    else if (pos >= POS_PULSE_LO && pos < POS_CHECKSUM)
      staged.pulse_low = {staged.pulse_low[7:0], b};
    else if (pos >= POS_PULSE_HI && pos < POS_LAST)
      staged.pulse_high = {staged.pulse_high[23:0], b};
    else if (pos == POS_LAST) begin
      frame_pos = int'(FRAME_LEN);
      if (b == TRAILER) close_frame();
    end
  endtask

  task automatic check_reading(input pmfp_out_t got);
    pmfp_out_t want;
    if (readings_q.size() == 0) begin
      report_mismatch($sformatf("reading for device %0d with none expected", got.out_device));
      return;
    end
    want = readings_q.pop_front();
    compare_field("out_device", 48'(got.out_device), 48'(want.out_device));
    compare_field("state_reg", 48'(got.state_reg), 48'(want.state_reg));
    compare_field("voltage_param", 48'(got.voltage_param), 48'(want.voltage_param));
    compare_field("voltage_data", 48'(got.voltage_data), 48'(want.voltage_data));
    compare_field("current_param", 48'(got.current_param), 48'(want.current_param));
    compare_field("current_data", 48'(got.current_data), 48'(want.current_data));
    compare_field("power_param", 48'(got.power_param), 48'(want.power_param));
    compare_field("power_data", 48'(got.power_data), 48'(want.power_data));
    compare_field("total_pulses", got.total_pulses, want.total_pulses);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_pos = int'(FRAME_LEN);
      staged = '0;
      foreach (kept[i]) kept[i] = '0;
      readings_q.delete();
    end else begin
      if (in_valid && !in_stall) take_beat(in_data);
      if (out_valid && !out_stall) check_reading(out_data);
    end
    readings_due <= readings_q.size();
  end

endmodule

>>> dv/power_meter_frame_parser_test.sv
`timescale 1ns / 1ps
module power_meter_frame_parser_test;
  import pmfp_pkg::*;

  localparam int DEVICES        = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BEATS   = 1300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  pmfp_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  pmfp_out_t out_data;

  int fail_count;
  int readings_due;
  int frame_beats;
  int hold_left;
  int quiet_cycles;
  bit calm_tx;
  bit calm_rx;

  always #5 clk = ~clk;

  power_meter_frame_parser #(.DEVICE_COUNT(DEVICES)) dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  pmfp_reading_checker #(.DEVICE_COUNT(DEVICES)) reading_check (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .fail_count, .readings_due
  );

  // Receiver: after each reading is taken, stall the next one for a random hold
  // counted while it is valid; calm_rx turns the hold off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) hold_left = calm_rx ? 0 : $urandom_range(0, 7);
      else if (out_valid && hold_left > 0) hold_left = hold_left - 1;
      out_stall <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[power_meter_frame_parser] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input pmfp_in_t beat);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [7:0] frame_byte(input pmfp_frame_t f, input int pos,
                                            input logic [7:0] trailer);
    logic [7:0] b;
    b = 8'($urandom);  // unused byte and checksum carry anything
    if (pos == POS_STATE) b = f.state;
    else if (pos >= POS_VPARAM && pos < POS_VDATA) b = f.vparam[8*(POS_VDATA-1-pos) +: 8];
    else if (pos >= POS_VDATA && pos < POS_CPARAM) b = f.vdata[8*(POS_CPARAM-1-pos) +: 8];
    else if (pos >= POS_CPARAM && pos < POS_CDATA) b = f.cparam[8*(POS_CDATA-1-pos) +: 8];
    else if (pos >= POS_CDATA && pos < POS_PPARAM) b = f.cdata[8*(POS_PPARAM-1-pos) +: 8];
    else if (pos >= POS_PPARAM && pos < POS_PDATA) b = f.pparam[8*(POS_PDATA-1-pos) +: 8];
    else if (pos >= POS_PDATA && pos < POS_FLAGS) b = f.pdata[8*(POS_FLAGS-1-pos) +: 8];
    else if (pos == POS_FLAGS) b = f.flags;
    else if (pos >= POS_PULSE_LO && pos < POS_CHECKSUM)
      b = f.pulse_low[8*(POS_CHECKSUM-1-pos) +: 8];
    else if (pos >= POS_PULSE_HI && pos < POS_LAST)
      b = f.pulse_high[8*(POS_LAST-1-pos) +: 8];
    else if (pos == POS_LAST) b = trailer;
    return b;
  endfunction

  // Sends the first 'length' bytes of a frame. Only the start beat carries the
  // real device and relay; the other beats carry junk there.
  task automatic send_frame(input pmfp_frame_t f, input logic [7:0] trailer, input int length);
    pmfp_in_t beat;
    for (int pos = 0; pos < length; pos++) begin
      beat.data_byte    = frame_byte(f, pos, trailer);
      beat.frame_start  = (pos == 0);
      beat.device_index = (pos == 0) ? f.device : DEV_W'($urandom);
      beat.relay_on     = (pos == 0) ? f.relay : 1'($urandom);
      send_beat(beat);
      frame_beats++;
    end
  endtask

  task automatic send_noise(input int count);
    pmfp_in_t beat;
    repeat (count) begin
      beat.data_byte    = 8'($urandom);
      beat.frame_start  = 1'b0;
      beat.device_index = DEV_W'($urandom);
      beat.relay_on     = 1'($urandom);
      send_beat(beat);
    end
  endtask

  function automatic logic [23:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic pmfp_frame_t random_frame();
    pmfp_frame_t f;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      f.state = TRAILER;
    end else if (pick < 7) begin
      f.state = OVF_MASK | 8'($urandom_range(0, 15));
      if ($urandom_range(0, 1)) f.state[ST_OVF_N] = 1'b0;
    end else begin
      f.state = 8'($urandom);
    end
    // A few devices get most frames so that kept values are reused.
    f.device     = $urandom_range(0, 1) ? DEV_W'($urandom_range(0, 3)) : DEV_W'($urandom);
    f.relay      = 1'($urandom);
    f.flags      = 8'($urandom);
    f.vparam     = pick_value();
    f.vdata      = pick_value();
    f.cparam     = pick_value();
    f.cdata      = pick_value();
    f.pparam     = pick_value();
    f.pdata      = pick_value();
    f.pulse_low  = 16'($urandom);
    f.pulse_high = $urandom;
    return f;
  endfunction

  initial begin
    pmfp_frame_t d;
    int          pick;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Largest values everywhere, normal state with the relay off.
    d = random_frame();
    d.device = '0;
    d.relay  = 1'b0;
    d.state  = TRAILER;
    d.flags  = '1;
    d.vparam = '1; d.vdata = '1; d.cparam = '1; d.cdata = '1; d.pparam = '1; d.pdata = '1;
    d.pulse_low = '1; d.pulse_high = '1;
    send_frame(d, TRAILER, FRAME_LEN);

    // Overflow report with no update: kept values, current cleared by relay off.
    d.flags = '0;
    d.state = OVF_MASK;
    send_frame(d, TRAILER, FRAME_LEN);

    // Each overflow bit alone, relay on, fresh data.
    d.relay = 1'b1;
    d.flags = '0;
    d.flags[FLAG_V] = 1'b1; d.flags[FLAG_C] = 1'b1; d.flags[FLAG_P] = 1'b1;
    for (int s = ST_P; s <= ST_V; s++) begin
      d.state = OVF_MASK;
      d.state[s] = 1'b1;
      send_frame(d, TRAILER, FRAME_LEN);
    end

    // Overflow marker with bit 0 set is a bad state; so is zero.
    d.state = OVF_MASK;
    d.state[ST_OVF_N] = 1'b1;
    send_frame(d, TRAILER, FRAME_LEN);
    d.state = '0;
    send_frame(d, TRAILER, FRAME_LEN);

    // Highest device, smallest values.
    d.device = '1;
    d.state  = TRAILER;
    d.vparam = '0; d.vdata = '0; d.cparam = '0; d.cdata = '0; d.pparam = '0; d.pdata = '0;
    d.pulse_low = '0; d.pulse_high = '0;
    send_frame(d, TRAILER, FRAME_LEN);

    // Bad trailer, a frame cut short by a restart, then stray bytes.
    send_frame(random_frame(), ~TRAILER, FRAME_LEN);
    send_frame(random_frame(), TRAILER, 15);
    send_frame(random_frame(), TRAILER, FRAME_LEN);
    send_noise(3);

    frame_beats = 0;
    while (frame_beats < RANDOM_BEATS) begin
      calm_tx = ($urandom_range(0, 5) == 0);
      calm_rx = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 8)
        send_frame(random_frame(), $urandom_range(0, 9) ? TRAILER : 8'($urandom), FRAME_LEN);
      else if (pick == 8)
        send_frame(random_frame(), TRAILER, $urandom_range(1, POS_LAST));
      else
        send_noise($urandom_range(1, 5));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (readings_due != 0);
    repeat (16) @(posedge clk);

    if (fail_count == 0)
      $display("[power_meter_frame_parser] OK");
    else
      $display("[power_meter_frame_parser] ERROR");
    $finish;
  end

endmodule
